>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define SLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent must hold in the cycle after its antecedent.
`define SLC_ASSERT_NEXT(lbl, pre, post, msg) \
  `SLC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> sv/slc_pkg.sv
// Types, widths and arithmetic helpers of the sparse logistic classifier.
`timescale 1ns / 1ps
package slc_pkg;

  localparam int OP_W     = 2;
  localparam int COLUMN_W = 10;
  localparam int VALUE_W  = 32;
  localparam int SCORE_W  = 64;
  localparam int COUNT_W  = 32;
  localparam int FRAC_ALIGN = 16;
  localparam int COL_RANGE  = 2 ** COLUMN_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_FEATURE = 2'd1,
    OP_EMPTY   = 2'd2
  } op_e;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Signed add that clamps to the 64-bit range instead of wrapping.
  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
    return s[SCORE_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

endpackage

>>> sv/slc_if.sv
// Handshake channels of the sparse logistic classifier: items in, results out, bias writes.
`timescale 1ns / 1ps
interface slc_in_if import slc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [COLUMN_W-1:0]       column;
  logic signed [VALUE_W-1:0] feature_value;
  logic                      last;
  logic                      label;

  modport source (output valid, operation, column, feature_value, last, label,
                  input ready);
  modport sink   (input valid, operation, column, feature_value, last, label,
                  output ready);
endinterface

interface slc_out_if import slc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      predicted;
  logic                      correct;
  logic [COUNT_W-1:0]        correct_count;
  logic [COUNT_W-1:0]        row_count;

  modport source (output valid, score, predicted, correct, correct_count, row_count,
                  input ready);
  modport sink   (input valid, score, predicted, correct, correct_count, row_count,
                  output ready);
endinterface

interface slc_cfg_if import slc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] bias;

  modport source (output valid, bias, input ready);
  modport sink   (input valid, bias, output ready);
endinterface

>>> sv/slc_wmem.sv
// Weight store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module slc_wmem import slc_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic signed [VALUE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic signed [VALUE_W-1:0] rdata_o
);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sparse_logistic_classifier_eval.sv
// Sparse logistic classifier: weight store, row multiply-accumulate and scoring.
//
// Items arrive on feat_i. Operation write stores feature_value as the weight at
// column; operation feature adds feature_value * weight to the row sum; a feature
// with last set, or an empty-row item, closes the row. Each closed row yields one
// result on res_o: the Q32.32 score (row sum plus bias, saturated), the predicted
// class, whether it matched the label, and saturating running counts.
// cfg_i writes the Q16.16 bias at any time; it is meant to change only while idle.
// One item is accepted per cycle while feat_i.ready is high. A result reaches res_o
// through the pipeline registers in order: the accepting edge reads the weight, then
// multiply, accumulate and score each register the item in turn.
// The accumulate stage feeds back on itself, which sets the rate.
// Reset clears the row sum, the counters, the bias and all valid flags. The weight
// store is not cleared; a weight must be written before a feature reads it.
// When the receiver stalls, the result stays in the output register and items keep
// flowing; the pipeline halts only when a second finished row reaches the output
// while the first is still waiting, and feat_i.ready drops for that time.
`timescale 1ns / 1ps
module sparse_logistic_classifier_eval import slc_pkg::*; #(
  parameter int NUM_COLUMNS = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  slc_in_if.sink    feat_i,
  slc_cfg_if.sink   cfg_i,
  slc_out_if.source res_o
);

  localparam int DEPTH = (NUM_COLUMNS < COL_RANGE) ? NUM_COLUMNS : COL_RANGE;
  localparam int AW    = $clog2(DEPTH);

  logic adv, stall, acc, in_range, is_feat, is_empty;

  logic signed [VALUE_W-1:0] bias_q;

  logic                      a_valid_q, a_feat_q, a_emit_q, a_label_q, a_inr_q;
  logic signed [VALUE_W-1:0] a_val_q;
  logic signed [VALUE_W-1:0] rdata, w_sel;

  logic                      m_valid_q, m_feat_q, m_emit_q, m_label_q;
  logic signed [SCORE_W-1:0] m_prod_q, prod_d;

  logic signed [SCORE_W-1:0] row_sum_q, sum_d;
  logic signed [SCORE_W-1:0] s_sum_q;
  logic                      s_emit_q, s_label_q;

  logic signed [SCORE_W-1:0] score_d, score_q;
  logic                      pred_d, ok_d, pred_q, ok_q;
  logic                      out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]        rows_q, correct_q;

  // The pipeline halts only when a finished row would overwrite an unread result.
  assign stall = out_valid_q && !res_o.ready && s_emit_q;
  assign adv   = !stall;
  assign feat_i.ready = adv;
  assign acc   = feat_i.valid && adv;

  assign in_range = 32'(feat_i.column) < 32'(NUM_COLUMNS);
  assign is_feat  = feat_i.operation == OP_FEATURE;
  assign is_empty = feat_i.operation == OP_EMPTY;

  slc_wmem #(.DEPTH(DEPTH), .AW(AW)) u_wmem (
    .clk_i   (clk_i),
    .we_i    (acc && (feat_i.operation == OP_WRITE) && in_range),
    .waddr_i (feat_i.column[AW-1:0]),
    .wdata_i (feat_i.feature_value),
    .re_i    (acc),
    .raddr_i (feat_i.column[AW-1:0]),
    .rdata_o (rdata)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
    end else if (cfg_i.valid) begin
      bias_q <= cfg_i.bias;
    end
  end

  // Weight read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= acc && (is_feat || is_empty);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_feat_q  <= is_feat;
      a_emit_q  <= is_empty || (is_feat && feat_i.last);
      a_label_q <= feat_i.label;
      a_inr_q   <= in_range;
      a_val_q   <= feat_i.feature_value;
    end
  end

  // Multiply stage: a column beyond the store reads as a zero weight.
  assign w_sel  = a_inr_q ? rdata : '0;
  assign prod_d = SCORE_W'(a_val_q) * SCORE_W'(w_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_valid_q) begin
      m_feat_q  <= a_feat_q;
      m_emit_q  <= a_emit_q;
      m_label_q <= a_label_q;
      m_prod_q  <= prod_d;
    end
  end

  // Accumulate stage: the row sum clears as a closed row moves on.
  assign sum_d = m_feat_q ? sat_add(row_sum_q, m_prod_q) : row_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
      s_emit_q  <= 1'b0;
    end else if (adv) begin
      s_emit_q <= m_valid_q && m_emit_q;
      if (m_valid_q) begin
        row_sum_q <= m_emit_q ? '0 : sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && m_valid_q) begin
      s_sum_q   <= sum_d;
      s_label_q <= m_label_q;
    end
  end

  // Score stage: bias is Q16.16, aligned to Q32.32 before the add.
  assign score_d = sat_add(s_sum_q,
                           {{(SCORE_W-VALUE_W-FRAC_ALIGN){bias_q[VALUE_W-1]}},
                            bias_q, {FRAC_ALIGN{1'b0}}});
  assign pred_d  = !score_d[SCORE_W-1];
  assign ok_d    = pred_d == s_label_q;

  assign out_valid_d = (adv && s_emit_q) || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rows_q      <= '0;
      correct_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv && s_emit_q) begin
        rows_q <= sat_inc(rows_q);
        if (ok_d) begin
          correct_q <= sat_inc(correct_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_emit_q) begin
      score_q <= score_d;
      pred_q  <= pred_d;
      ok_q    <= ok_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.score         = score_q;
  assign res_o.predicted     = pred_q;
  assign res_o.correct       = ok_q;
  assign res_o.correct_count = correct_q;
  assign res_o.row_count     = rows_q;

endmodule

>>> sv/slc_checker.sv
// Port-level checks of the sparse logistic classifier and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slc_checker import slc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      feat_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic signed [SCORE_W-1:0] score,
  input logic                      predicted,
  input logic [COUNT_W-1:0]        correct_count,
  input logic [COUNT_W-1:0]        row_count
);

  `SLC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(score), "result lost")
  `SLC_ASSERT(a_pred_sign, res_valid |-> (predicted == !score[SCORE_W-1]), "bad predicted")
  `SLC_ASSERT(a_counts, res_valid |-> (row_count != '0 && correct_count <= row_count), "bad counts")
  `SLC_ASSERT(a_stall_cause, !feat_ready |-> (res_valid && !res_ready), "needless input stall")

endmodule

bind sparse_logistic_classifier_eval slc_checker u_slc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .feat_ready    (feat_i.ready),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .score         (res_o.score),
  .predicted     (res_o.predicted),
  .correct_count (res_o.correct_count),
  .row_count     (res_o.row_count)
);
